### design/cpf_pkg.sv
package cpf_pkg;

	localparam int unsigned MaxPayload = 251;
	localparam int unsigned QDepth     = 2;
	localparam int unsigned QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int unsigned QCntW      = $clog2(QDepth + 1);

	localparam logic [7:0]  FLAG_HI   = 8'h33;
	localparam logic [7:0]  FLAG_LO   = 8'h17;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [7:0]  LEN_EXTRA = 8'd4;
	localparam logic [7:0]  MAX_LEN   = 8'(MaxPayload);

	// byte positions within a header job
	localparam logic [2:0] STEP_FLAG_HI = 3'd0;
	localparam logic [2:0] STEP_FLAG_LO = 3'd1;
	localparam logic [2:0] STEP_LEN     = 3'd2;
	localparam logic [2:0] STEP_ID_HI   = 3'd3;
	localparam logic [2:0] STEP_ID_LO   = 3'd4;
	localparam logic [2:0] STEP_CRC_HI  = 3'd5;
	localparam logic [2:0] STEP_CRC_LO  = 3'd6;

	// input opcodes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	typedef enum logic [0:0] {
		JOB_HDR  = 1'b0,
		JOB_DATA = 1'b1
	} job_kind_t;

	// one unit of work handed from the front to the back
	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  byte0;   // length byte for a header, payload byte otherwise
		logic [15:0] id;
		logic [15:0] crc;     // CRC after this item
		logic        close;   // append CRC and end the frame
	} job_t;

	// fold one byte into the CRC, MSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        msb;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			msb = c[15];
			c   = {c[14:0], 1'b0};
			if (msb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// CRC contribution of one identifier bit, starting from zero
	function automatic logic [15:0] crc_col(input int i);
		logic [15:0] v;
		logic        msb;
		v = 16'(1) << i;
		for (int k = 0; k < 16; k++) begin
			msb = v[15];
			v   = {v[14:0], 1'b0};
			if (msb) begin
				v = v ^ CRC_POLY;
			end
		end
		return v;
	endfunction

	// CRC of the 16-bit identifier as a sum of independent columns
	function automatic logic [15:0] crc_of_id(input logic [15:0] id);
		logic [15:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (id[i]) begin
				r = r ^ crc_col(i);
			end
		end
		return r;
	endfunction

endpackage

### design/crc16_packet_framer.sv
// channel  direction  handshake             payload
// in       sink       in_valid / in_ready   op, data_byte, payload_len, can_id
// out      source     out_valid / out_ready tx_byte, last_of_run, end_of_frame
//
// A start item emits five bytes, or seven with the CRC when the payload length is
// zero; a payload item emits one, or three when it closes the frame. The byte
// serializer in the back end sends one byte per cycle unless the output stalls.
// Input accept is one item per cycle while the two-entry job queue has room.
// Asynchronous reset closes any frame and clears the CRC; no clearing pass.
// A stalled output holds its byte; the front keeps taking items until full.
module crc16_packet_framer import cpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  payload_len,
	input  logic [15:0] can_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        last_of_run,
	output logic        end_of_frame
);

	logic q_full;
	logic q_push;
	job_t q_job;
	logic q_pop;
	logic q_head_valid;
	job_t q_head_job;

	cpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.data_byte   (data_byte),
		.payload_len (payload_len),
		.can_id      (can_id),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_job)
	);

	cpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	cpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head_job     (q_head_job),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tx_byte      (tx_byte),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule

### design/cpf_front.sv
module cpf_front import cpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  payload_len,
	input  logic [15:0] can_id,
	input  logic        q_full,
	output logic        q_push,
	output job_t        q_job
);

	logic        in_frame_q;
	logic [7:0]  bytes_left_q;
	logic [15:0] crc_q;

	logic        accept;
	logic [7:0]  len_sat;
	logic [15:0] id_crc;
	logic [15:0] data_crc;
	logic [7:0]  left_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// classify the item and build its job
	always_comb begin
		len_sat   = (payload_len > MAX_LEN) ? MAX_LEN : payload_len;
		id_crc    = crc_of_id(can_id);
		data_crc  = crc_fold(crc_q, data_byte);
		left_next = bytes_left_q - 8'd1;
		q_job     = '0;
		q_push    = 1'b0;
		if (op == OP_START) begin
			q_job.kind  = JOB_HDR;
			q_job.byte0 = len_sat + LEN_EXTRA;
			q_job.id    = can_id;
			q_job.crc   = id_crc;
			q_job.close = (len_sat == 8'd0);
			q_push      = accept;
		end else begin
			q_job.kind  = JOB_DATA;
			q_job.byte0 = data_byte;
			q_job.id    = can_id;
			q_job.crc   = data_crc;
			q_job.close = (left_next == 8'd0);
			q_push      = accept && in_frame_q;
		end
	end

	// update frame state; drop payload outside a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
			crc_q        <= '0;
		end else if (accept) begin
			if (op == OP_START) begin
				crc_q        <= id_crc;
				bytes_left_q <= len_sat;
				in_frame_q   <= (len_sat != 8'd0);
			end else if (in_frame_q) begin
				crc_q        <= data_crc;
				bytes_left_q <= left_next;
				in_frame_q   <= (left_next != 8'd0);
			end
		end
	end

	a_frame_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> bytes_left_q != 8'd0)
		else $error("open frame with no bytes left");

	a_left_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q <= MAX_LEN)
		else $error("bytes left above maximum payload");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

endmodule

### design/cpf_queue.sv
module cpf_queue import cpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full       = (count_q == QCntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	// hold job payloads
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("queue count overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

### design/cpf_back.sv
module cpf_back import cpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       last_of_run,
	output logic       end_of_frame
);

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] tx_byte_q;
	logic       last_q;
	logic       eof_q;

	logic       advance;
	logic       emit;
	logic [2:0] last_step;
	logic       is_last;
	logic [7:0] sel_byte;

	assign advance = !out_valid_q || out_ready;
	assign emit    = advance && head_valid;

	// pick the byte for the current step of the head job
	always_comb begin
		sel_byte = '0;
		if (head_job.kind == JOB_HDR) begin
			last_step = head_job.close ? STEP_CRC_LO : STEP_ID_LO;
			case (step_q)
				STEP_FLAG_HI: sel_byte = FLAG_HI;
				STEP_FLAG_LO: sel_byte = FLAG_LO;
				STEP_LEN:     sel_byte = head_job.byte0;
				STEP_ID_HI:   sel_byte = head_job.id[15:8];
				STEP_ID_LO:   sel_byte = head_job.id[7:0];
				STEP_CRC_HI:  sel_byte = head_job.crc[15:8];
				STEP_CRC_LO:  sel_byte = head_job.crc[7:0];
				default:      sel_byte = '0;
			endcase
		end else begin
			// payload byte, then CRC when the frame closes
			last_step = head_job.close ? 3'd2 : 3'd0;
			case (step_q)
				3'd0:    sel_byte = head_job.byte0;
				3'd1:    sel_byte = head_job.crc[15:8];
				3'd2:    sel_byte = head_job.crc[7:0];
				default: sel_byte = '0;
			endcase
		end
		is_last = (step_q == last_step);
	end

	assign pop = emit && is_last;

	// step through the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (emit) begin
				step_q <= is_last ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	// load the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			tx_byte_q <= sel_byte;
			last_q    <= is_last;
			eof_q     <= is_last && head_job.close;
		end
	end

	assign out_valid    = out_valid_q;
	assign tx_byte      = tx_byte_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eof_q |-> last_q)
		else $error("frame end not on last byte of item");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_CRC_LO)
		else $error("step counter out of range");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> step_q == 3'd0)
		else $error("step left over with no job");

endmodule
